@@ hw/rtl/ltr_pkg.sv @@
package ltr_pkg;

    // width of the result value field
    localparam int VALUE_W = 48;

    // ascii codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_DIVZERO   = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    // request from the sequencer to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
        logic neg;
    } alu_req_t;

    // status back from the multiply/divide unit
    typedef struct packed {
        logic done;
        logic ovf;
    } alu_rsp_t;

    function automatic op_t char_to_op(input logic [7:0] ch);
        op_t op;
        case (ch)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default:  op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

@@ hw/rtl/ltr_if.sv @@
interface ltr_expr_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       is_last;

    modport source (output valid, output character, output is_last, input ready);
    modport sink   (input valid, input character, input is_last, output ready);
endinterface

interface ltr_result_if;
    import ltr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    status_t                   status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

@@ hw/rtl/ltr_muldiv.sv @@
module ltr_muldiv #(
    parameter int ACC_WIDTH     = 48,
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ltr_pkg::alu_req_t           req,
    input  logic [ACC_WIDTH-1:0]        mag,
    input  logic [OPERAND_WIDTH-1:0]    operand,
    output ltr_pkg::alu_rsp_t           rsp,
    output logic [ACC_WIDTH-1:0]        result
);
    import ltr_pkg::*;

    localparam int SW = (ACC_WIDTH > OPERAND_WIDTH) ? ACC_WIDTH : OPERAND_WIDTH;
    localparam int AW = SW + 1;
    localparam int CW = $clog2(SW + 1);
    localparam int PW = ACC_WIDTH + OPERAND_WIDTH;

    typedef enum logic [1:0] {U_IDLE, U_RUN, U_DONE} ustate_t;

    ustate_t          state_reg, state_next;
    logic [AW-1:0]    r_reg, r_next;
    logic [SW-1:0]    s_reg, s_next;
    logic [SW-1:0]    m_reg, m_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             div_reg, div_next;
    logic             neg_reg, neg_next;

    logic [AW:0]          ea, eb, sum;
    logic                 ge;
    logic [SW-1:0]        s_shr;
    logic [PW-1:0]        prod;
    logic [ACC_WIDTH-1:0] mag_res;

    // shared adder: add for multiply, trial subtract for divide
    always_comb
    begin
        if (div_reg)
        begin
            ea  = {1'b0, r_reg[AW-2:0], s_reg[ACC_WIDTH-1]};
            eb  = {1'b0, AW'(m_reg)};
            sum = ea - eb;
        end
        else
        begin
            ea  = {1'b0, r_reg};
            eb  = s_reg[0] ? {1'b0, AW'(m_reg)} : '0;
            sum = ea + eb;
        end
    end

    assign ge = ~sum[AW];

    always_comb
    begin
        s_shr                  = s_reg >> 1;
        s_shr[OPERAND_WIDTH-1] = sum[0];
    end

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        s_next     = s_reg;
        m_next     = m_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    r_next   = '0;
                    div_next = req.is_div;
                    neg_next = req.neg;
                    if (req.is_div)
                    begin
                        s_next   = SW'(mag);
                        m_next   = SW'(operand);
                        cnt_next = CW'(ACC_WIDTH);
                    end
                    else
                    begin
                        s_next   = SW'(operand);
                        m_next   = SW'(mag);
                        cnt_next = CW'(OPERAND_WIDTH);
                    end
                    state_next = U_RUN;
                end
            end
            U_RUN:
            begin
                if (div_reg)
                begin
                    r_next = ge ? sum[AW-1:0] : ea[AW-1:0];
                    s_next = {s_reg[SW-2:0], ge};
                end
                else
                begin
                    r_next = sum[AW:1];
                    s_next = s_shr;
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = U_DONE;
                end
            end
            U_DONE:
            begin
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            r_reg     <= '0;
            s_reg     <= '0;
            m_reg     <= '0;
            cnt_reg   <= '0;
            div_reg   <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            s_reg     <= s_next;
            m_reg     <= m_next;
            cnt_reg   <= cnt_next;
            div_reg   <= div_next;
            neg_reg   <= neg_next;
        end
    end

    // product and quotient magnitude
    assign prod    = {r_reg[ACC_WIDTH-1:0], s_reg[OPERAND_WIDTH-1:0]};
    assign mag_res = div_reg ? s_reg[ACC_WIDTH-1:0] : prod[ACC_WIDTH-1:0];
    assign result  = neg_reg ? (ACC_WIDTH'(0) - mag_res) : mag_res;

    // product must stay within the signed range for its sign
    assign rsp.done = (state_reg == U_DONE);
    assign rsp.ovf  = ~div_reg & ((|prod[PW-1:ACC_WIDTH])
                    | (prod[ACC_WIDTH-1] & (~neg_reg | (|prod[ACC_WIDTH-2:0]))));

endmodule

@@ hw/rtl/left_to_right_expression_calc.sv @@
// Left-to-right expression calculator. Takes an ASCII expression one
// character per transaction on expr, the last character flagged by is_last,
// and evaluates decimal integer operands with + - * / strictly left to right
// (no precedence) in signed fixed point with FRAC_BITS fraction bits. One
// transaction comes out on result per expression, after its last character:
// the value (zero unless status is ok) and a status of ok, malformed,
// division by zero or overflow. Malformed wins over every other error;
// otherwise the first arithmetic error is kept. A digit that does not end
// the expression is collected in S_IDLE. An operator, or the final digit,
// folds the collected operand into the accumulator: + and - in S_FOLD, and
// * and / through S_WAIT on the shared shift-add / restoring-divide unit
// that handles one bit per cycle.
// The last character then needs one more cycle to load the output register,
// which may be held off while an earlier result has not been taken.
// expr.ready is low while a fold or the output load is in progress.
module left_to_right_expression_calc #(
    parameter int ACC_WIDTH     = 48,
    parameter int FRAC_BITS     = 16,
    parameter int OPERAND_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    ltr_expr_if.sink       expr,
    ltr_result_if.source   result
);
    import ltr_pkg::*;

    // operand scaled to fixed point, and a width that holds any fold sum
    localparam int QW = OPERAND_WIDTH + FRAC_BITS;
    localparam int WW = ((ACC_WIDTH > QW) ? ACC_WIDTH : QW) + 2;

    typedef enum logic [1:0] {S_IDLE, S_FOLD, S_WAIT, S_FINISH} state_t;

    state_t                         state_reg, state_next;
    logic signed [ACC_WIDTH-1:0]    acc_reg, acc_next;
    logic [OPERAND_WIDTH-1:0]       opnd_reg, opnd_next;
    op_t                            pend_reg, pend_next;
    op_t                            nop_reg, nop_next;
    logic                           prev_digit_reg, prev_digit_next;
    status_t                        err_reg, err_next;
    logic                           last_reg, last_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0]      value_reg, value_next;
    status_t                        status_reg, status_next;

    logic                           accept;
    logic                           is_digit;
    op_t                            char_op;
    logic [3:0]                     digit;
    logic [OPERAND_WIDTH+3:0]       digit_val;
    logic                           digit_ovf;

    logic signed [WW-1:0]           acc_ext;
    logic [WW-1:0]                  q_ext;
    logic signed [WW-1:0]           fold_sum;
    logic                           fold_fits;

    logic                           acc_neg;
    logic [ACC_WIDTH-1:0]           acc_mag;
    alu_req_t                       alu_req;
    alu_rsp_t                       alu_rsp;
    logic [ACC_WIDTH-1:0]           alu_result;

    logic                           fold_end;
    logic                           out_free;

    assign accept   = expr.valid & expr.ready;
    assign is_digit = (expr.character >= CH_ZERO) && (expr.character <= CH_NINE);
    assign char_op  = char_to_op(expr.character);
    assign digit    = 4'(expr.character - CH_ZERO);

    // operand times ten plus the new digit
    assign digit_val = ((OPERAND_WIDTH+4)'(opnd_reg) << 3)
                     + ((OPERAND_WIDTH+4)'(opnd_reg) << 1)
                     + (OPERAND_WIDTH+4)'(digit);
    assign digit_ovf = |digit_val[OPERAND_WIDTH+3:OPERAND_WIDTH];

    // load, add or subtract the scaled operand; range check on the wide sum
    assign acc_ext = WW'(acc_reg);
    assign q_ext   = WW'(opnd_reg) << FRAC_BITS;

    always_comb
    begin
        case (pend_reg)
            OP_ADD:  fold_sum = acc_ext + $signed(q_ext);
            OP_SUB:  fold_sum = acc_ext - $signed(q_ext);
            default: fold_sum = $signed(q_ext);
        endcase
    end

    assign fold_fits = (&fold_sum[WW-1:ACC_WIDTH-1]) | ~(|fold_sum[WW-1:ACC_WIDTH-1]);

    // sign and magnitude for multiply and divide
    assign acc_neg = acc_reg[ACC_WIDTH-1];
    assign acc_mag = acc_neg ? (ACC_WIDTH'(0) - acc_reg) : acc_reg;

    assign alu_req.start  = (state_reg == S_FOLD)
                          && ((pend_reg == OP_MUL) || (pend_reg == OP_DIV))
                          && (opnd_reg != '0);
    assign alu_req.is_div = (pend_reg == OP_DIV);
    assign alu_req.neg    = acc_neg;

    ltr_muldiv #(
        .ACC_WIDTH     (ACC_WIDTH),
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_muldiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (alu_req),
        .mag     (acc_mag),
        .operand (opnd_reg),
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    assign out_free = ~out_valid_reg | result.ready;

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        opnd_next       = opnd_reg;
        pend_next       = pend_reg;
        nop_next        = nop_reg;
        prev_digit_next = prev_digit_reg;
        err_next        = err_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg & ~result.ready;
        value_next      = value_reg;
        status_next     = status_reg;
        fold_end        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = expr.is_last;
                    if (is_digit)
                    begin
                        if (err_reg == ST_OK)
                        begin
                            if (digit_ovf)
                            begin
                                err_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                opnd_next = digit_val[OPERAND_WIDTH-1:0];
                            end
                        end
                        prev_digit_next = 1'b1;
                        if (expr.is_last)
                        begin
                            // final digit folds only while no error is held
                            if ((err_reg == ST_OK) && !digit_ovf)
                            begin
                                state_next = S_FOLD;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                    end
                    else
                    begin
                        prev_digit_next = 1'b0;
                        if (char_op == OP_NONE)
                        begin
                            err_next = ST_MALFORMED;
                        end
                        else if (!prev_digit_reg)
                        begin
                            err_next = ST_MALFORMED;
                        end
                        else if (err_reg == ST_OK)
                        begin
                            nop_next   = char_op;
                            state_next = S_FOLD;
                        end
                        // ending on a non-digit is malformed whatever came before
                        if (expr.is_last)
                        begin
                            err_next   = ST_MALFORMED;
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            S_FOLD:
            begin
                case (pend_reg)
                    OP_MUL:
                    begin
                        if (opnd_reg == '0)
                        begin
                            acc_next = '0;
                            fold_end = 1'b1;
                        end
                        else
                        begin
                            state_next = S_WAIT;
                        end
                    end
                    OP_DIV:
                    begin
                        if (opnd_reg == '0)
                        begin
                            err_next = ST_DIVZERO;
                            fold_end = 1'b1;
                        end
                        else
                        begin
                            state_next = S_WAIT;
                        end
                    end
                    OP_NONE, OP_ADD, OP_SUB:
                    begin
                        if (fold_fits)
                        begin
                            acc_next = fold_sum[ACC_WIDTH-1:0];
                        end
                        else
                        begin
                            err_next = ST_OVERFLOW;
                        end
                        fold_end = 1'b1;
                    end
                    default:
                    begin
                        fold_end = 1'b1;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    if (alu_rsp.ovf)
                    begin
                        err_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        acc_next = alu_result;
                    end
                    fold_end = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    value_next      = (err_reg == ST_OK) ? VALUE_W'(acc_reg) : '0;
                    status_next     = err_reg;
                    // clear for the next expression
                    acc_next        = '0;
                    opnd_next       = '0;
                    pend_next       = OP_NONE;
                    prev_digit_next = 1'b0;
                    err_next        = ST_OK;
                    last_next       = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // after a fold: either produce the result or arm the new operator
        if (fold_end)
        begin
            if (last_reg)
            begin
                state_next = S_FINISH;
            end
            else
            begin
                pend_next  = nop_reg;
                opnd_next  = '0;
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            acc_reg        <= '0;
            opnd_reg       <= '0;
            pend_reg       <= OP_NONE;
            nop_reg        <= OP_NONE;
            prev_digit_reg <= 1'b0;
            err_reg        <= ST_OK;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            value_reg      <= '0;
            status_reg     <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            opnd_reg       <= opnd_next;
            pend_reg       <= pend_next;
            nop_reg        <= nop_next;
            prev_digit_reg <= prev_digit_next;
            err_reg        <= err_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
            value_reg      <= value_next;
            status_reg     <= status_next;
        end
    end

    assign expr.ready    = (state_reg == S_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.value  = value_reg;
    assign result.status = status_reg;

endmodule

@@ hw/rtl/ltr_checker.sv @@
module ltr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              in_last,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [ltr_pkg::VALUE_W-1:0] out_value,
    input ltr_pkg::status_t                  out_status
);
    import ltr_pkg::*;

    // a waiting result stays offered
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid;
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result dropped before it was taken");

    // a waiting result keeps its payload
    property p_out_stable;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(out_status);
    endproperty
    a_out_stable: assert property (p_out_stable)
        else $error("result payload changed while stalled");

    // an error result carries a zero value
    property p_err_zero;
        @(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != ST_OK) |-> (out_value == '0);
    endproperty
    a_err_zero: assert property (p_err_zero)
        else $error("non-ok result with non-zero value");

    // the last character always leads to a busy cycle for the result
    property p_last_busy;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready;
    endproperty
    a_last_busy: assert property (p_last_busy)
        else $error("input taken straight after the final character");

endmodule

bind left_to_right_expression_calc ltr_checker u_ltr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (expr.valid),
    .in_ready   (expr.ready),
    .in_last    (expr.is_last),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_value  (result.value),
    .out_status (result.status)
);

@@ bench/tb_left_to_right_expression_calc.sv @@
`timescale 1ns / 100ps

module tb_left_to_right_expression_calc;
    import ltr_pkg::*;

    // sizes of the block as built
    localparam int ACC_W  = 48;
    localparam int FRAC_W = 16;
    localparam int OPND_W = 32;

    localparam longint unsigned ACC_MAX  = (64'd1 << (ACC_W - 1)) - 64'd1;
    localparam longint unsigned OPND_MAX = (64'd1 << OPND_W) - 64'd1;

    // run length and limits
    localparam int CHAR_TARGET    = 1850;
    localparam int CALM_TAIL      = 250;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int SETTLE_CYCLES  = ACC_W + 12;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int REPORT_MAX     = 10;

    typedef struct {
        logic signed [ACC_W-1:0] value;
        status_t                 status;
    } answer_t;

    // one directed expression; typed rows carry a hand-written answer
    typedef struct {
        string                   text;
        bit                      typed;
        logic signed [ACC_W-1:0] value;
        status_t                 status;
    } probe_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ltr_expr_if   expr_if ();
    ltr_result_if res_if ();

    left_to_right_expression_calc #(
        .ACC_WIDTH     (ACC_W),
        .FRAC_BITS     (FRAC_W),
        .OPERAND_WIDTH (OPND_W)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .expr   (expr_if),
        .result (res_if)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // evaluator state: mirrors the running expression inside the block
    // ------------------------------------------------------------------
    longint signed   eval_acc;
    longint unsigned eval_opnd;
    op_t             eval_op;
    bit              eval_after_digit;
    status_t         eval_err;

    answer_t         answers_due[$];    // results still owed by the block
    logic [7:0]      line_buf[$];       // characters of the expression being sent

    int  chars_sent     = 0;
    int  mismatch_count = 0;
    int  gap_odds       = 0;            // sender idles once in gap_odds transactions, 0 = never
    bit  calm           = 1'b0;         // final stretch with no idling at all
    bit  squeeze_go     = 1'b0;         // asks the result side for its long hold-off
    int  cycle_count    = 0;

    function automatic void eval_clear();
        eval_acc         = 0;
        eval_opnd        = 0;
        eval_op          = OP_NONE;
        eval_after_digit = 1'b0;
        eval_err         = ST_OK;
    endfunction

    // first arithmetic error sticks
    function automatic void eval_raise(status_t code);
        if (eval_err == ST_OK)
            eval_err = code;
    endfunction

    // fold the collected operand into the accumulator under the pending operator
    function automatic void eval_fold();
        longint signed   smax;
        longint signed   smin;
        longint signed   scaled_s;
        longint unsigned scaled;
        longint unsigned mag;
        longint unsigned bound;
        bit              neg;

        smax     = longint'(ACC_MAX);
        smin     = -smax - 1;
        scaled   = eval_opnd << FRAC_W;
        scaled_s = longint'(scaled);
        neg      = eval_acc < 0;
        mag      = neg ? $unsigned(-eval_acc) : $unsigned(eval_acc);
        bound    = neg ? ACC_MAX + 64'd1 : ACC_MAX;

        case (eval_op)
            OP_NONE:
                if (scaled > ACC_MAX)
                    eval_raise(ST_OVERFLOW);
                else
                    eval_acc = scaled_s;
            OP_ADD:
                if (eval_acc > smax - scaled_s)
                    eval_raise(ST_OVERFLOW);
                else
                    eval_acc = eval_acc + scaled_s;
            OP_SUB:
                if (eval_acc < smin + scaled_s)
                    eval_raise(ST_OVERFLOW);
                else
                    eval_acc = eval_acc - scaled_s;
            OP_MUL:
                if (eval_opnd == 0)
                    eval_acc = 0;
                else if (mag > bound / eval_opnd)
                    eval_raise(ST_OVERFLOW);
                else
                begin
                    mag      = mag * eval_opnd;
                    eval_acc = neg ? -longint'(mag) : longint'(mag);
                end
            OP_DIV:
                if (eval_opnd == 0)
                    eval_raise(ST_DIVZERO);
                else
                begin
                    // magnitude division truncates toward zero
                    mag      = mag / eval_opnd;
                    eval_acc = neg ? -longint'(mag) : longint'(mag);
                end
            default: ;
        endcase
    endfunction

    // feed one character; returns 1 when it closes an expression
    function automatic bit eval_char(input logic [7:0] ch, input logic last,
                                     output answer_t ans);
        bit              digit;
        op_t             op;
        longint unsigned grown;

        digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        case (ch)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default:  op = OP_NONE;
        endcase

        if (digit)
        begin
            if (eval_err == ST_OK)
            begin
                grown = eval_opnd * 10 + longint'(ch - CH_ZERO);
                if (grown > OPND_MAX)
                    eval_raise(ST_OVERFLOW);
                else
                    eval_opnd = grown;
            end
            eval_after_digit = 1'b1;
        end
        else if (op != OP_NONE)
        begin
            // an operator must follow a digit; malformed overrides anything
            if (!eval_after_digit)
                eval_err = ST_MALFORMED;
            else if (eval_err == ST_OK)
            begin
                eval_fold();
                eval_op   = op;
                eval_opnd = 0;
            end
            eval_after_digit = 1'b0;
        end
        else
        begin
            eval_err         = ST_MALFORMED;
            eval_after_digit = 1'b0;
        end

        ans = '{value: '0, status: ST_OK};
        if (!last)
            return 1'b0;

        if (!digit)
            eval_err = ST_MALFORMED;
        else if (eval_err == ST_OK)
            eval_fold();

        ans.status = eval_err;
        if (eval_err == ST_OK)
            ans.value = eval_acc[ACC_W-1:0];
        eval_clear();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // random expression builder
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // mostly well-formed expressions with random operands; a quarter are
    // noise, stray bytes, trailing or leading operators
    function automatic void compose_expression();
        int mode;
        int terms;
        int digits;
        int roll;
        int t;
        int d;

        line_buf.delete();
        mode = $urandom_range(0, 19);

        if (mode == 0)
        begin
            repeat ($urandom_range(1, 8))
                line_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end

        terms = $urandom_range(1, 5);
        for (t = 0; t < terms; t++)
        begin
            if (t != 0)
                line_buf.push_back(pick_operator());
            // short operands mostly, now and then long enough to overflow
            roll = $urandom_range(0, 19);
            if (roll < 12)
                digits = $urandom_range(1, 2);
            else if (roll < 18)
                digits = $urandom_range(3, 5);
            else
                digits = $urandom_range(6, 11);
            for (d = 0; d < digits; d++)
                line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end

        case (mode)
            1: line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
            2: line_buf[$urandom_range(0, line_buf.size() - 1)] = pick_operator();
            3: line_buf.push_back(pick_operator());
            4: line_buf.push_front(pick_operator());
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sender: one transaction per character, is_last on the final one
    // ------------------------------------------------------------------
    task automatic send_line(input bit typed, input answer_t typed_ans);
        answer_t ans;
        logic    last;
        int      i;

        for (i = 0; i < line_buf.size(); i++)
        begin
            last = (i == line_buf.size() - 1);
            if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
            begin
                expr_if.valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            expr_if.valid     <= 1'b1;
            expr_if.character <= line_buf[i];
            expr_if.is_last   <= last;
            do
                @(posedge clk);
            while (!expr_if.ready);

            // transaction taken at this edge
            if (eval_char(line_buf[i], last, ans))
                answers_due.push_back(typed ? typed_ans : ans);
            chars_sent++;
            if (chars_sent >= CHAR_TARGET - CALM_TAIL)
                calm = 1'b1;
        end
    endtask

    // directed expressions; an empty text stands for a lone nul character
    probe_row_t probes[] = '{
        '{"",           1'b1, '0, ST_MALFORMED},   // nul byte, lowest character
        '{"\377",       1'b1, '0, ST_MALFORMED},   // top byte, not a digit
        '{"9+8-3*2/4",  1'b0, '0, ST_OK},          // every operator, strictly in order
        '{"1/0",        1'b1, '0, ST_DIVZERO},
        '{"+5",         1'b1, '0, ST_MALFORMED},   // leading operator
        '{"9/0+*1",     1'b1, '0, ST_MALFORMED},   // doubled operator beats division by zero
        '{"4294967296", 1'b1, '0, ST_OVERFLOW},    // operand one past 32 bits
        '{"2147483648", 1'b1, '0, ST_OVERFLOW}     // integer part beyond the accumulator
    };

    initial
    begin : stimulus
        int      r;
        int      i;
        answer_t row_ans;

        expr_if.valid     <= 1'b0;
        expr_if.character <= '0;
        expr_if.is_last   <= 1'b0;
        eval_clear();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (r = 0; r < probes.size(); r++)
        begin
            line_buf.delete();
            if (probes[r].text.len() == 0)
                line_buf.push_back(8'h00);
            else
                for (i = 0; i < probes[r].text.len(); i++)
                    line_buf.push_back(probes[r].text[i]);
            row_ans = '{value: probes[r].value, status: probes[r].status};
            send_line(probes[r].typed, row_ans);
        end

        // random part; the result side holds off once while characters keep coming
        squeeze_go = 1'b1;
        while (chars_sent < CHAR_TARGET)
        begin
            case ($urandom_range(0, 3))
                0, 1: gap_odds = 0;
                2:    gap_odds = 3;
                default: gap_odds = 8;
            endcase
            compose_expression();
            send_line(1'b0, row_ans);
        end
        expr_if.valid <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random hold-off bursts, one long hold-off to fill the block
    // ------------------------------------------------------------------
    initial
    begin : result_drain
        int  odds;
        int  window;
        bit  squeezed;

        odds     = 0;
        window   = 0;
        squeezed = 1'b0;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (window == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       odds = 0;
                    1:       odds = 4;
                    default: odds = 12;
                endcase
                window = 64;
            end
            window--;

            if (squeeze_go && !squeezed)
            begin
                res_if.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeezed = 1'b1;
            end
            else if (!calm && odds != 0 && $urandom_range(1, odds) == 1)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endfunction

    always @(posedge clk)
    begin : result_check
        answer_t due;

        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (answers_due.size() == 0)
                note_mismatch($sformatf("unexpected result value %0d status %s",
                                        res_if.value, res_if.status.name()));
            else
            begin
                due = answers_due.pop_front();
                if (res_if.value !== due.value)
                    note_mismatch($sformatf("value expected %0d got %0d",
                                            due.value, res_if.value));
                if (res_if.status !== due.status)
                    note_mismatch($sformatf("status expected %s got %s",
                                            due.status.name(), res_if.status.name()));
            end
        end
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
